### rtl/tcd_pkg.sv
// ----------------------------------------------------------------------------
// tcd_pkg
// Shared types and constants of the two-class task dispatcher.
// ----------------------------------------------------------------------------
package tcd_pkg;

  // Default sizes
  localparam int unsigned DEF_QUEUE_DEPTH   = 16;
  localparam int unsigned DEF_STACK_DEPTH   = 16;
  localparam int unsigned DEF_TASK_ID_WIDTH = 16;

  // Priority field width and the priority that goes to the stack
  localparam int unsigned PRI_W = 4;
  localparam logic [PRI_W-1:0] HIGH_PRI = 4'd1;

  // Request kinds
  typedef enum logic {
    REQ_INSERT   = 1'b0,
    REQ_DISPATCH = 1'b1
  } req_type_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_INSERTED   = 2'd0,
    ST_DROPPED    = 2'd1,
    ST_DISPATCHED = 2'd2,
    ST_EMPTY      = 2'd3
  } status_t;

endpackage

### rtl/two_class_task_dispatcher.sv
// ----------------------------------------------------------------------------
// two_class_task_dispatcher
// Task queue with a high-priority stack in front of a FIFO.
// ----------------------------------------------------------------------------
// Takes one request per cycle unless the result channel stalls, and returns
// exactly one result per request, via the input then the result register. An
// insert of priority 1 is pushed on a LIFO stack, any other priority is
// appended to a FIFO; an insert into a full store is dropped with status 1.
// A dispatch pops the stack top when the stack is non-empty and the FIFO is
// empty or its head has priority 0, otherwise it pops the FIFO head; with
// both empty it returns status 3. The sustained rate of one request per
// cycle is set by the single read port of each store: the FIFO head and the
// stack top are prefetched every cycle into registers, addressed by the
// pointers that the request in flight leaves behind, with a bypass when
// that request writes the very entry being prefetched. No clearing pass is
// needed after reset; entries are only read after they were written.
// ----------------------------------------------------------------------------
module two_class_task_dispatcher #(
  parameter int unsigned QUEUE_DEPTH   = tcd_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned STACK_DEPTH   = tcd_pkg::DEF_STACK_DEPTH,
  parameter int unsigned TASK_ID_WIDTH = tcd_pkg::DEF_TASK_ID_WIDTH,
  // Packed tdata width: task id plus priority, rounded up to whole bytes
  parameter int unsigned TDATA_W = ((TASK_ID_WIDTH + tcd_pkg::PRI_W + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst_n,
  // Request channel
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // [TASK_ID_WIDTH-1:0] task_id, next 4 priority_req
  input  logic               in_tuser,   // [0] req_type
  // Result channel
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // [TASK_ID_WIDTH-1:0] out_task_id, next 4 out_priority
  output logic [2:0]         out_tuser   // [1:0] status, [2] from_stack
);
  import tcd_pkg::*;

  localparam int unsigned IDW = TASK_ID_WIDTH;
  localparam int unsigned QA  = $clog2(QUEUE_DEPTH);
  localparam int unsigned QC  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SA  = $clog2(STACK_DEPTH);
  localparam int unsigned SC  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned QEW = IDW + PRI_W;   // FIFO entry: {priority, id}

  // --------------------------------------------------------------------------
  // Request register
  // --------------------------------------------------------------------------
  logic             req_v_r;
  req_type_t        req_type_r;
  logic [IDW-1:0]   req_id_r;
  logic [PRI_W-1:0] req_pri_r;

  // Result register
  logic             out_v_r;
  status_t          res_status_r;
  logic [IDW-1:0]   res_id_r;
  logic [PRI_W-1:0] res_pri_r;
  logic             res_stk_r;

  logic advance;   // result register can take a new value
  logic fire;      // request in the input register is processed this cycle
  logic in_acc;

  assign advance   = !out_v_r || out_tready;
  assign fire      = req_v_r && advance;
  assign in_tready = !req_v_r || advance;
  assign in_acc    = in_tvalid && in_tready;

  // --------------------------------------------------------------------------
  // Store state
  // --------------------------------------------------------------------------
  logic [QEW-1:0] q_mem [QUEUE_DEPTH];
  logic [IDW-1:0] s_mem [STACK_DEPTH];

  logic [QA-1:0]  q_head_r, q_head_nxt;
  logic [QA-1:0]  q_tail_r, q_tail_nxt;
  logic [QC-1:0]  q_cnt_r,  q_cnt_nxt;
  logic [SC-1:0]  s_cnt_r,  s_cnt_nxt;

  // prefetched FIFO head and stack top for the current state
  logic [QEW-1:0] q_rd_r;
  logic [IDW-1:0] s_rd_r;

  logic           q_we, s_we;
  logic [SA-1:0]  s_rd_addr;

  status_t          res_status_nxt;
  logic [IDW-1:0]   res_id_nxt;
  logic [PRI_W-1:0] res_pri_nxt;
  logic             res_stk_nxt;

  logic q_empty, s_empty, q_full, s_full;
  logic [PRI_W-1:0] q_head_pri;

  assign q_empty    = (q_cnt_r == '0);
  assign s_empty    = (s_cnt_r == '0);
  assign q_full     = (q_cnt_r == QC'(QUEUE_DEPTH));
  assign s_full     = (s_cnt_r == SC'(STACK_DEPTH));
  assign q_head_pri = q_rd_r[QEW-1:IDW];

  // --------------------------------------------------------------------------
  // Request decode and next state
  // --------------------------------------------------------------------------
  always_comb begin
    q_head_nxt     = q_head_r;
    q_tail_nxt     = q_tail_r;
    q_cnt_nxt      = q_cnt_r;
    s_cnt_nxt      = s_cnt_r;
    q_we           = 1'b0;
    s_we           = 1'b0;
    res_status_nxt = ST_INSERTED;
    res_id_nxt     = '0;
    res_pri_nxt    = '0;
    res_stk_nxt    = 1'b0;

    if (fire) begin
      case (req_type_r)
        REQ_INSERT: begin
          if (req_pri_r == HIGH_PRI) begin
            if (s_full) begin
              res_status_nxt = ST_DROPPED;
            end else begin
              s_we      = 1'b1;
              s_cnt_nxt = s_cnt_r + 1'b1;
            end
          end else begin
            if (q_full) begin
              res_status_nxt = ST_DROPPED;
            end else begin
              q_we       = 1'b1;
              q_tail_nxt = (q_tail_r == QA'(QUEUE_DEPTH - 1)) ? '0 : q_tail_r + 1'b1;
              q_cnt_nxt  = q_cnt_r + 1'b1;
            end
          end
        end
        REQ_DISPATCH: begin
          // stack wins unless the FIFO head has priority above 0
          if (!s_empty && (q_empty || (q_head_pri < HIGH_PRI))) begin
            s_cnt_nxt      = s_cnt_r - 1'b1;
            res_status_nxt = ST_DISPATCHED;
            res_id_nxt     = s_rd_r;
            res_pri_nxt    = HIGH_PRI;
            res_stk_nxt    = 1'b1;
          end else if (!q_empty) begin
            q_head_nxt     = (q_head_r == QA'(QUEUE_DEPTH - 1)) ? '0 : q_head_r + 1'b1;
            q_cnt_nxt      = q_cnt_r - 1'b1;
            res_status_nxt = ST_DISPATCHED;
            res_id_nxt     = q_rd_r[IDW-1:0];
            res_pri_nxt    = q_head_pri;
          end else begin
            res_status_nxt = ST_EMPTY;
          end
        end
        default: begin
          res_status_nxt = ST_EMPTY;
        end
      endcase
    end
  end

  // stack top after this cycle; entry 0 when the stack will be empty
  assign s_rd_addr = (s_cnt_nxt == '0) ? '0 : SA'(s_cnt_nxt - 1'b1);

  // --------------------------------------------------------------------------
  // Stores with registered prefetch of FIFO head and stack top
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_tail_r] <= {req_pri_r, req_id_r};
    end
    // write to the entry that becomes the head: forward the new data
    if (q_we && (q_tail_r == q_head_nxt)) begin
      q_rd_r <= {req_pri_r, req_id_r};
    end else begin
      q_rd_r <= q_mem[q_head_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      s_mem[s_cnt_r[SA-1:0]] <= req_id_r;
    end
    // a push always lands on the new top: forward it
    if (s_we) begin
      s_rd_r <= req_id_r;
    end else begin
      s_rd_r <= s_mem[s_rd_addr];
    end
  end

  // --------------------------------------------------------------------------
  // Control and payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_v_r  <= 1'b0;
      out_v_r  <= 1'b0;
      q_head_r <= '0;
      q_tail_r <= '0;
      q_cnt_r  <= '0;
      s_cnt_r  <= '0;
    end else begin
      q_head_r <= q_head_nxt;
      q_tail_r <= q_tail_nxt;
      q_cnt_r  <= q_cnt_nxt;
      s_cnt_r  <= s_cnt_nxt;
      if (in_acc) begin
        req_v_r <= 1'b1;
      end else if (advance) begin
        req_v_r <= 1'b0;
      end
      if (advance) begin
        out_v_r <= req_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_type_r <= req_type_t'(in_tuser);
      req_id_r   <= in_tdata[IDW-1:0];
      req_pri_r  <= in_tdata[IDW+PRI_W-1:IDW];
    end
    if (fire) begin
      res_status_r <= res_status_nxt;
      res_id_r     <= res_id_nxt;
      res_pri_r    <= res_pri_nxt;
      res_stk_r    <= res_stk_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = TDATA_W'({res_pri_r, res_id_r});
  assign out_tuser  = {res_stk_r, res_status_r};

endmodule
